### rtl/icp_pkg.sv
// Package for the IPv4 CIDR text parser: field widths, character codes,
// parser state and result types, shared by the interfaces and the RTL modules.
// Depends on nothing.
package icp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned OctetW  = 8;
  localparam int unsigned PrefixW = 6;
  localparam int unsigned PartW   = 3;
  localparam int unsigned NumOct  = 4;

  localparam logic [CharW-1:0]   DotChar    = 8'h2E;
  localparam logic [CharW-1:0]   SlashChar  = 8'h2F;
  localparam logic [CharW-1:0]   DigitZero  = 8'h30;
  localparam logic [CharW-1:0]   DigitNine  = 8'h39;
  localparam logic [OctetW-1:0]  MaxPrefix  = 8'd32;
  localparam logic [PrefixW-1:0] FullPrefix = 6'd32;

  // Part numbers: three octets closed by '.', the fourth closed by '/'.
  localparam logic [PartW-1:0] PartLastDot = 3'd2;
  localparam logic [PartW-1:0] PartFourth  = 3'd3;
  localparam logic [PartW-1:0] PartPrefix  = 3'd4;

  typedef struct packed {
    logic [OctetW-1:0]             running_value;
    logic                          seen_digit;
    logic [PartW-1:0]              part_index;
    logic [NumOct-1:0][OctetW-1:0] captured_octets;
    logic                          error_seen;
  } parse_state_t;

  typedef struct packed {
    logic              is_valid;
    logic [OctetW-1:0] octet_a;
    logic [OctetW-1:0] octet_b;
    logic [OctetW-1:0] octet_c;
    logic [OctetW-1:0] octet_d;
    logic [PrefixW-1:0] prefix_length;
  } parse_result_t;

  localparam parse_state_t StateClear = '0;

endpackage

### rtl/icp_if.sv
// Valid/ready channel interfaces for the IPv4 CIDR text parser: the character
// channel and the result channel. Depends on icp_pkg.
interface icp_char_if;
  import icp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface icp_result_if;
  import icp_pkg::*;
  logic               valid;
  logic               ready;
  logic               is_valid;
  logic [OctetW-1:0]  octet_a;
  logic [OctetW-1:0]  octet_b;
  logic [OctetW-1:0]  octet_c;
  logic [OctetW-1:0]  octet_d;
  logic [PrefixW-1:0] prefix_length;

  modport source (output valid, is_valid, octet_a, octet_b, octet_c, octet_d,
                  prefix_length, input ready);
  modport sink   (input valid, is_valid, octet_a, octet_b, octet_c, octet_d,
                  prefix_length, output ready);
endinterface

### rtl/ipv4_cidr_text_parser_core.sv
// Top level of the IPv4 CIDR text parser: input register, parser state,
// step logic and result register. Depends on icp_pkg, icp_if and icp_step.
//
// Usage: the text of an IPv4 address, optionally with a "/prefix" suffix,
// arrives on in_ch one character per item, with end_of_text low. An item
// with end_of_text high is the terminator; its char_code is ignored. Each
// terminator produces exactly one item on res_ch: is_valid, the four octets
// and the prefix length (32 when no suffix was given). When the text is
// invalid every octet and the prefix read zero. Character items produce no
// result item. After the terminator the parser starts afresh.
//
// Throughput is one item per cycle unless a terminator waits for the result
// register: the state update is a single combinational multiply-by-ten (two
// shifted adds) and a compare. An accepted terminator is held in the input
// register; its result is loaded into the result register once that register
// is free, and is then offered on res_ch.
// When res_ch stalls, character items keep flowing; a second terminator
// waits in the input register until the pending result has been taken, and
// in_ch.ready stays low while it waits. Synchronous reset empties both
// registers and clears the parser state, so the first item after reset
// starts a new text.
module ipv4_cidr_text_parser_core (
  input  logic               clk,
  input  logic               rst,
  icp_char_if.sink           in_ch,
  icp_result_if.source       res_ch
);
  import icp_pkg::*;

  // Input register.
  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             in_eot;

  // Parser state, updated as each registered item is consumed.
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t result_next;

  // Result register.
  logic          res_valid;
  parse_result_t res_data;

  logic res_free;
  logic advance;

  icp_step u_step (
    .state       (state),
    .char_code   (in_char),
    .end_of_text (in_eot),
    .state_next  (state_next),
    .result      (result_next)
  );

  // The result register can take a new value when empty or being drained.
  assign res_free = !res_valid || res_ch.ready;
  // A character item always moves on; a terminator needs room for its result.
  assign advance  = in_valid && (!in_eot || res_free);

  assign in_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_char <= in_ch.char_code;
      in_eot  <= in_ch.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateClear;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_eot) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_eot) begin
      res_data <= result_next;
    end
  end

  assign res_ch.valid         = res_valid;
  assign res_ch.is_valid      = res_data.is_valid;
  assign res_ch.octet_a       = res_data.octet_a;
  assign res_ch.octet_b       = res_data.octet_b;
  assign res_ch.octet_c       = res_data.octet_c;
  assign res_ch.octet_d       = res_data.octet_d;
  assign res_ch.prefix_length = res_data.prefix_length;

endmodule

### rtl/icp_step.sv
// Combinational per-character step of the IPv4 CIDR text parser: next parser
// state and, for a terminator, the result. Depends on icp_pkg.
module icp_step (
  input  icp_pkg::parse_state_t          state,
  input  logic [icp_pkg::CharW-1:0]      char_code,
  input  logic                           end_of_text,
  output icp_pkg::parse_state_t          state_next,
  output icp_pkg::parse_result_t         result
);
  import icp_pkg::*;

  logic              is_digit;
  logic [3:0]        digit;
  logic [11:0]       value_ext;
  logic              too_large;
  parse_state_t      after_char;
  parse_state_t      closed;
  logic              ok;
  logic              at_fourth;
  logic              at_prefix;

  assign is_digit  = (char_code >= DigitZero) && (char_code <= DigitNine);
  assign digit     = 4'(char_code - DigitZero);
  // Ten times the value as two shifted copies, plus the new digit.
  assign value_ext = {1'b0, state.running_value, 3'b000}
                   + {3'b000, state.running_value, 1'b0}
                   + {8'h00, digit};
  assign too_large = |value_ext[11:8];

  always_comb begin
    closed = state;
    closed.captured_octets[state.part_index[1:0]] = state.running_value;
    closed.part_index    = state.part_index + 3'd1;
    closed.running_value = '0;
    closed.seen_digit    = 1'b0;
  end

  always_comb begin
    after_char = state;
    if (!state.error_seen) begin
      priority if (is_digit) begin
        if (too_large) begin
          after_char.error_seen = 1'b1;
        end else begin
          after_char.running_value = value_ext[7:0];
          after_char.seen_digit    = 1'b1;
        end
      end else if (char_code == DotChar) begin
        if (!state.seen_digit || (state.part_index > PartLastDot)) begin
          after_char.error_seen = 1'b1;
        end else begin
          after_char = closed;
        end
      end else if (char_code == SlashChar) begin
        if (!state.seen_digit || (state.part_index != PartFourth)) begin
          after_char.error_seen = 1'b1;
        end else begin
          after_char = closed;
        end
      end else begin
        after_char.error_seen = 1'b1;
      end
    end
  end

  assign state_next = end_of_text ? StateClear : after_char;

  assign at_fourth = (state.part_index == PartFourth);
  assign at_prefix = (state.part_index == PartPrefix);

  always_comb begin
    ok = !state.error_seen && state.seen_digit && (at_fourth || at_prefix);
    if (at_prefix && (state.running_value > MaxPrefix)) begin
      ok = 1'b0;
    end
    result = '0;
    if (ok) begin
      result.is_valid = 1'b1;
      result.octet_a  = state.captured_octets[0];
      result.octet_b  = state.captured_octets[1];
      result.octet_c  = state.captured_octets[2];
      if (at_fourth) begin
        result.octet_d       = state.running_value;
        result.prefix_length = FullPrefix;
      end else begin
        result.octet_d       = state.captured_octets[3];
        result.prefix_length = state.running_value[PrefixW-1:0];
      end
    end
  end

endmodule

### sim/ipv4_cidr_text_parser_core_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the IPv4 CIDR text parser: follows the address text on the
// character channel, works out each result and compares it with the result
// channel. Depends on icp_pkg and icp_if.
module ipv4_cidr_text_parser_core_checker (
  input  logic        clk,
  input  logic        rst,
  icp_char_if         in_ch,
  icp_result_if       res_ch,
  output int unsigned mismatch_count,
  output int unsigned results_outstanding
);
  import icp_pkg::*;

  localparam int unsigned OctetMax = 255;

  parse_state_t  scan;
  parse_result_t awaited_results[$];
  int unsigned   faults = 0;

  assign mismatch_count = faults;

  // Digits build the current part; a dot or slash closes it. Once the text is
  // spoilt nothing more is taken until the terminator.
  function automatic parse_state_t absorb_char(parse_state_t s, logic [CharW-1:0] c);
    int unsigned grown;
    if (s.error_seen) return s;
    if (c >= DigitZero && c <= DigitNine) begin
      grown = int'(s.running_value) * 10 + int'(c - DigitZero);
      if (grown > OctetMax) begin
        s.error_seen = 1'b1;
      end else begin
        s.running_value = OctetW'(grown);
        s.seen_digit    = 1'b1;
      end
    end else if ((c == DotChar && s.seen_digit && s.part_index <= PartLastDot) ||
                 (c == SlashChar && s.seen_digit && s.part_index == PartFourth)) begin
      s.captured_octets[s.part_index[1:0]] = s.running_value;
      s.part_index    = s.part_index + PartW'(1);
      s.running_value = '0;
      s.seen_digit    = 1'b0;
    end else begin
      s.error_seen = 1'b1;
    end
    return s;
  endfunction

  function automatic parse_result_t close_text(parse_state_t s);
    parse_result_t r;
    r = '0;
    if (!s.error_seen && s.seen_digit) begin
      if (s.part_index == PartFourth) begin
        r.is_valid      = 1'b1;
        r.octet_d       = s.running_value;
        r.prefix_length = FullPrefix;
      end else if (s.part_index == PartPrefix && s.running_value <= MaxPrefix) begin
        r.is_valid      = 1'b1;
        r.octet_d       = s.captured_octets[3];
        r.prefix_length = PrefixW'(s.running_value);
      end
      if (r.is_valid) begin
        r.octet_a = s.captured_octets[0];
        r.octet_b = s.captured_octets[1];
        r.octet_c = s.captured_octets[2];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      scan = StateClear;
      awaited_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.end_of_text) begin
          awaited_results.push_back(close_text(scan));
          scan = StateClear;
        end else begin
          scan = absorb_char(scan, in_ch.char_code);
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no expectation waiting");
          faults++;
        end else begin
          want = awaited_results.pop_front();
          check_field("is_valid", 8'(want.is_valid), 8'(res_ch.is_valid));
          check_field("octet_a", want.octet_a, res_ch.octet_a);
          check_field("octet_b", want.octet_b, res_ch.octet_b);
          check_field("octet_c", want.octet_c, res_ch.octet_c);
          check_field("octet_d", want.octet_d, res_ch.octet_d);
          check_field("prefix_length", 8'(want.prefix_length), 8'(res_ch.prefix_length));
        end
      end
    end
    results_outstanding <= awaited_results.size();
  end

endmodule

### sim/ipv4_cidr_text_parser_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the IPv4 CIDR text parser: clock, reset, address text
// stimulus and result-side back-pressure, with the checker beside the block.
// Depends on icp_pkg, icp_if, the parser RTL and the checker.
module ipv4_cidr_text_parser_core_tb;
  import icp_pkg::*;

  localparam int ClkPeriod      = 12;
  localparam int HoldCycles     = 300;
  localparam int RunLimitCycles = 200000;
  localparam int TailCycles     = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Local copies of every driven channel signal, so that all block inputs are
  // known from time zero.
  logic             feed_valid  = 1'b0;
  logic [CharW-1:0] feed_char   = '0;
  logic             feed_eot    = 1'b0;
  logic             take_result = 1'b0;

  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 53;
  logic        pressure_on   = 1'b0;
  int unsigned hold_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned mismatch_count;
  int unsigned results_outstanding;

  // Address text waiting to be sent, one character per entry.
  logic [CharW-1:0] text_buf[$];

  icp_char_if   in_ch ();
  icp_result_if res_ch ();

  assign in_ch.valid       = feed_valid;
  assign in_ch.char_code   = feed_char;
  assign in_ch.end_of_text = feed_eot;
  assign res_ch.ready      = take_result;

  ipv4_cidr_text_parser_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .res_ch (res_ch)
  );

  ipv4_cidr_text_parser_core_checker scoreboard (
    .clk                 (clk),
    .rst                 (rst),
    .in_ch               (in_ch),
    .res_ch              (res_ch),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Result side. Once the pressure phase starts, the receiver refuses results
  // for a long stretch, so a second terminator backs up and the block stalls
  // its character input. Otherwise it refuses at random.
  always @(posedge clk) begin
    if (rst) begin
      take_result <= 1'b0;
      hold_count  <= 0;
    end else if (pressure_on && hold_count < HoldCycles) begin
      take_result <= 1'b0;
      hold_count  <= hold_count + 1;
    end else begin
      take_result <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one item and returns just after the edge at which it was taken.
  // The ready line is looked at on the falling edge, where it has settled.
  task automatic offer_item(input logic [CharW-1:0] c, input logic eot);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      feed_valid <= 1'b0;
      @(posedge clk);
    end
    feed_valid <= 1'b1;
    feed_char  <= c;
    feed_eot   <= eot;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Sends the buffered text, then the terminator with a random character code,
  // which the block has to ignore.
  task automatic send_text();
    foreach (text_buf[i]) offer_item(text_buf[i], 1'b0);
    offer_item(CharW'($urandom_range(255)), 1'b1);
    text_buf.delete();
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Writes a decimal number with the given count of leading zeros.
  task automatic push_decimal(input int unsigned value, input int unsigned zeros);
    logic [CharW-1:0] digits[$];
    repeat (zeros) text_buf.push_back(DigitZero);
    do begin
      digits.push_front(DigitZero + CharW'(value % 10));
      value = value / 10;
    end while (value != 0);
    foreach (digits[i]) text_buf.push_back(digits[i]);
  endtask

  // A well-formed dotted quad with random content. The prefix, when present,
  // is sometimes too large, up to values that overflow a byte.
  task automatic build_address();
    int unsigned octet_val;
    int unsigned prefix_val;
    for (int k = 0; k < NumOct; k++) begin
      case ($urandom_range(7))
        0:       octet_val = 0;
        1:       octet_val = 255;
        2:       octet_val = $urandom_range(9);
        3:       octet_val = $urandom_range(99);
        default: octet_val = $urandom_range(255);
      endcase
      push_decimal(octet_val, ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
      if (k < NumOct - 1) text_buf.push_back(DotChar);
    end
    if ($urandom_range(1) == 1) begin
      case ($urandom_range(9))
        0:       prefix_val = 32;
        1:       prefix_val = 0;
        2:       prefix_val = $urandom_range(33, 99);
        3:       prefix_val = $urandom_range(100, 999);
        default: prefix_val = $urandom_range(32);
      endcase
      text_buf.push_back(SlashChar);
      push_decimal(prefix_val, ($urandom_range(7) == 0) ? 1 : 0);
    end
  endtask

  // Alters a well-formed address in one place, in a way that may spoil it.
  task automatic break_address();
    int unsigned pos;
    logic [CharW-1:0] extra;
    pos = $urandom_range(text_buf.size() - 1);
    case ($urandom_range(4))
      0: text_buf[pos] = CharW'($urandom_range(255));
      1: text_buf.delete(pos);
      2: begin
        case ($urandom_range(2))
          0:       extra = DotChar;
          1:       extra = SlashChar;
          default: extra = DigitZero + CharW'($urandom_range(9));
        endcase
        text_buf.insert(pos, extra);
      end
      3: while (text_buf.size() > pos) void'(text_buf.pop_back());
      default: begin
        text_buf.push_back(($urandom_range(1) == 1) ? DotChar : SlashChar);
        push_decimal($urandom_range(999), 0);
      end
    endcase
  endtask

  // Short runs of characters, biased towards the ones the parser cares about.
  task automatic build_noise();
    repeat ($urandom_range(12)) begin
      case ($urandom_range(3))
        0:       text_buf.push_back(DigitZero + CharW'($urandom_range(9)));
        1:       text_buf.push_back(DotChar);
        2:       text_buf.push_back(SlashChar);
        default: text_buf.push_back(CharW'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic random_texts(input int unsigned item_goal);
    int unsigned pick;
    while (items_sent < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        build_address();
      end else if (pick < 90) begin
        build_address();
        break_address();
      end else begin
        build_noise();
      end
      send_text();
    end
  endtask

  initial begin
    string directed_texts[16];

    // Empty text, extremes of the octets and the prefix, leading zeros, and
    // each way the text can go wrong.
    directed_texts = '{
      "", "00.0.0.000/00", "255.255.255.255", "1.2.3.4/32", "9.8.7.6/33",
      "1.2.3.4/", "1.2.3", "256", ".1", "1..2", "1.2.3.4.5", "1.2/3",
      "1.2.3.4/5/6", "x1.2.3.4", "10.20.30.40 ", "12.34.56.78/300"
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_texts[i]) begin
      push_string(directed_texts[i]);
      send_text();
    end

    // Sender flat out while the receiver holds off.
    send_idle_pct = 0;
    pressure_on <= 1'b1;
    repeat (6) begin
      build_address();
      send_text();
    end

    send_idle_pct = 9;
    random_texts(550);

    send_idle_pct = 53;
    recv_idle_pct <= 9;
    random_texts(1050);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    random_texts(1550);

    feed_valid <= 1'b0;
    do @(negedge clk); while (results_outstanding != 0);
    repeat (TailCycles) @(posedge clk);

    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("ipv4_cidr_text_parser_core_tb: done, clean");
    end else begin
      $display("ipv4_cidr_text_parser_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(RunLimitCycles * ClkPeriod);
    $display("ipv4_cidr_text_parser_core_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/icp_pkg.sv
rtl/icp_if.sv
rtl/icp_step.sv
rtl/ipv4_cidr_text_parser_core.sv
sim/ipv4_cidr_text_parser_core_checker.sv
sim/ipv4_cidr_text_parser_core_tb.sv
